>>> rtl/core/slbd_pkg.sv
package slbd_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CountWidth = 32;
	localparam int unsigned ByteWidth  = 8;
	localparam int unsigned CfgIdxWidth = 2;

	localparam logic [2:0] GroupsNarrow = 3'd3;
	localparam logic [2:0] GroupsWide   = 3'd5;
	localparam logic [5:0] BitsNarrow   = 6'd16;
	localparam logic [5:0] BitsWide     = 6'd32;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LONG  = 2'd1,
		ST_PAST_SIZE = 2'd2,
		ST_LEFT_OVER = 2'd3
	} slbd_status_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_WIDE_VALUES = 2'd0,
		CFG_BLOCK_BYTES = 2'd1,
		CFG_VALUE_COUNT = 2'd2
	} slbd_cfg_idx_t;

	typedef struct packed {
		logic [ValueWidth-1:0] value;
		logic [CountWidth-1:0] index;
		slbd_status_t          status;
		logic                  last;
	} slbd_res_t;

endpackage

>>> rtl/core/signed_leb128_block_decoder_unit.sv
// Each accepted byte is held in the input register; the decode state updates from it in one pass.
// Throughput: one byte per cycle while the skid register is empty.
// An output register plus a skid register keep the input moving while a result waits.
// Reset (arst_n low) clears the pipeline, the decode state and the registers to
// 16-bit values, block size zero and value count one.
module signed_leb128_block_decoder_unit
	import slbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [63:0]            m_axis_tdata,   // [31:0] decoded_value, [63:32] value_index
	output logic [1:0]             m_axis_tuser,   // [1:0] status
	output logic                   m_axis_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CfgIdxWidth-1:0] cfg_index,
	input  logic [CountWidth-1:0]  cfg_data
);

	logic      res_valid;
	slbd_res_t res;
	logic      out_valid_q;
	slbd_res_t out_q;
	logic      skid_valid_q;
	slbd_res_t skid_q;
	logic      out_free;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_axis_tready;

	slbd_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.adv       (!skid_valid_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.index, out_q.value};
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds an item while the output register is empty");

	a_error_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast)
		else $error("error result does not end the block");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata[31:0] == '0)
		else $error("error result carries a nonzero value");

	a_no_result_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !res_valid)
		else $error("result produced while both output registers are full");

endmodule

>>> rtl/core/slbd_dec.sv
module slbd_dec
	import slbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [ByteWidth-1:0]   in_byte,
	input  logic                   cfg_wr,
	input  logic [CfgIdxWidth-1:0] cfg_idx,
	input  logic [CountWidth-1:0]  cfg_wdata,
	input  logic                   adv,
	output logic                   res_valid,
	output slbd_res_t              res
);

	logic                  valid_s1;
	logic [ByteWidth-1:0]  byte_s1;

	logic                  wide_q;
	logic [CountWidth-1:0] block_bytes_q;
	logic [CountWidth-1:0] value_count_q;

	logic [ValueWidth-1:0] partial_q;
	logic [2:0]            group_q;
	logic [CountWidth-1:0] bytes_left_q;
	logic [CountWidth-1:0] done_q;
	logic                  stopped_q;

	logic [ValueWidth-1:0] partial_n;
	logic [2:0]            group_n;
	logic [CountWidth-1:0] bytes_left_n;
	logic [CountWidth-1:0] done_n;
	logic                  stopped_n;

	logic                  work;
	logic                  cfg_hit;
	logic [CountWidth-1:0] restart_bytes;
	logic [5:0]            shift;
	logic [5:0]            fill_shift;
	logic [5:0]            width_bits;
	logic [ValueWidth-1:0] width_mask;
	logic [ValueWidth-1:0] acc;
	logic [ValueWidth-1:0] value;
	logic [2:0]            group_inc;
	logic [2:0]            group_limit;
	logic [CountWidth-1:0] done_inc;

	assign in_ready = !valid_s1 || adv;
	assign work     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		cfg_hit = 1'b0;
		unique case (cfg_idx)
			CFG_WIDE_VALUES, CFG_BLOCK_BYTES, CFG_VALUE_COUNT: cfg_hit = cfg_wr;
			default: cfg_hit = 1'b0;
		endcase
	end

	assign restart_bytes = (cfg_idx == CFG_BLOCK_BYTES) ? cfg_wdata : block_bytes_q;

	always_comb begin
		width_bits  = wide_q ? BitsWide : BitsNarrow;
		width_mask  = wide_q ? 32'hffff_ffff : 32'h0000_ffff;
		group_limit = wide_q ? GroupsWide : GroupsNarrow;
		shift       = 6'(group_q) * 6'd7;
		fill_shift  = shift + 6'd7;
		group_inc   = group_q + 3'd1;
		done_inc    = done_q + 32'd1;

		acc = (partial_q | ({25'd0, byte_s1[6:0]} << shift)) & width_mask;
		value = acc;
		if (fill_shift < width_bits && byte_s1[6]) begin
			value = acc | ((32'hffff_ffff << fill_shift) & width_mask);
		end
		if (!wide_q) begin
			value = {{16{value[15]}}, value[15:0]};
		end

		partial_n    = partial_q;
		group_n      = group_q;
		bytes_left_n = bytes_left_q;
		done_n       = done_q;
		stopped_n    = stopped_q;
		res_valid    = 1'b0;
		res          = '{value: '0, index: done_q, status: ST_OK, last: 1'b0};

		if (work && !stopped_q) begin
			if (bytes_left_q == '0) begin
				stopped_n  = 1'b1;
				res_valid  = 1'b1;
				res.status = ST_PAST_SIZE;
				res.last   = 1'b1;
			end else begin
				bytes_left_n = bytes_left_q - 32'd1;
				if (byte_s1[7]) begin
					group_n   = group_inc;
					partial_n = acc;
					if (group_inc >= group_limit) begin
						stopped_n  = 1'b1;
						res_valid  = 1'b1;
						res.status = ST_TOO_LONG;
						res.last   = 1'b1;
					end
				end else begin
					partial_n = '0;
					group_n   = '0;
					done_n    = done_inc;
					res_valid = 1'b1;
					res.value = value;
					if (done_inc == value_count_q) begin
						stopped_n = 1'b1;
						res.last  = 1'b1;
						if (bytes_left_n != '0) begin
							res.value  = '0;
							res.status = ST_LEFT_OVER;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q        <= 1'b0;
			block_bytes_q <= '0;
			value_count_q <= 32'd1;
			partial_q     <= '0;
			group_q       <= '0;
			bytes_left_q  <= '0;
			done_q        <= '0;
			stopped_q     <= 1'b0;
		end else if (cfg_hit) begin
			unique case (cfg_idx)
				CFG_WIDE_VALUES: wide_q        <= cfg_wdata[0];
				CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata;
				CFG_VALUE_COUNT: value_count_q <= cfg_wdata;
				default: ;
			endcase
			partial_q    <= '0;
			group_q      <= '0;
			bytes_left_q <= restart_bytes;
			done_q       <= '0;
			stopped_q    <= 1'b0;
		end else begin
			partial_q    <= partial_n;
			group_q      <= group_n;
			bytes_left_q <= bytes_left_n;
			done_q       <= done_n;
			stopped_q    <= stopped_n;
		end
	end

	a_group_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!stopped_q |-> group_q < group_limit)
		else $error("group count reached the value width without stopping");

	a_stop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last && !cfg_hit |=> stopped_q)
		else $error("block did not stop after its last result");

	a_silent_when_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !res_valid)
		else $error("result produced after the block stopped");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import slbd_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int BytesPerPhase = 100;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'h00;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [63:0]            m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [CountWidth-1:0]  cfg_data = '0;

	signed_leb128_block_decoder_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #10 clk = ~clk;

	logic [7:0] body_bytes[$];
	logic [7:0] block_buf[$];
	slbd_res_t  pending_values[$];
	slbd_res_t  want;

	logic        wide_mode = 1'b0;
	logic [31:0] size_limit = 32'd0;
	logic [31:0] count_limit = 32'd1;
	logic [31:0] part_bits = 32'd0;
	logic [2:0]  group_idx = 3'd0;
	logic [31:0] bytes_remaining = 32'd0;
	logic [31:0] values_emitted = 32'd0;
	logic        block_ended = 1'b0;

	int errors = 0;
	int cycle_count = 0;
	int results_seen = 0;
	int live_bytes = 0;
	int blocks_run = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	bit in_fire = 1'b0;

	function automatic void restart_block();
		part_bits = 32'd0;
		group_idx = 3'd0;
		bytes_remaining = size_limit;
		values_emitted = 32'd0;
		block_ended = 1'b0;
	endfunction

	function automatic void load_register(slbd_cfg_idx_t idx, logic [31:0] d);
		case (idx)
			CFG_WIDE_VALUES: wide_mode = d[0];
			CFG_BLOCK_BYTES: size_limit = d;
			CFG_VALUE_COUNT: count_limit = d;
			default: return;
		endcase
		restart_block();
	endfunction

	function automatic void expect_value(logic [31:0] v, logic [31:0] idx, slbd_status_t st,
			logic fin);
		slbd_res_t r;
		r.value = v;
		r.index = idx;
		r.status = st;
		r.last = fin;
		pending_values.push_back(r);
	endfunction

	function automatic void decode_leb_byte(logic [7:0] b);
		int          width_bits;
		int          shift;
		logic [63:0] mask;
		logic [63:0] acc;
		logic [31:0] val;
		logic [31:0] idx;
		width_bits = wide_mode ? 32 : 16;
		mask = wide_mode ? 64'hffff_ffff : 64'hffff;
		if (block_ended)
			return;
		live_bytes++;
		if (bytes_remaining == 32'd0) begin
			block_ended = 1'b1;
			expect_value(32'd0, values_emitted, ST_PAST_SIZE, 1'b1);
			return;
		end
		bytes_remaining--;
		shift = 7 * int'(group_idx);
		acc = ({32'd0, part_bits} | ({57'd0, b[6:0]} << shift)) & mask;
		if (b[7]) begin
			group_idx = group_idx + 3'd1;
			part_bits = acc[31:0];
			if (7 * int'(group_idx) >= width_bits) begin
				block_ended = 1'b1;
				expect_value(32'd0, values_emitted, ST_TOO_LONG, 1'b1);
			end
			return;
		end
		if (shift + 7 < width_bits && b[6])
			acc = acc | ((~64'd0 << (shift + 7)) & mask);
		val = acc[31:0];
		if (!wide_mode && val[15])
			val[31:16] = 16'hffff;
		part_bits = 32'd0;
		group_idx = 3'd0;
		idx = values_emitted;
		values_emitted++;
		if (values_emitted == count_limit) begin
			block_ended = 1'b1;
			if (bytes_remaining != 32'd0)
				expect_value(32'd0, idx, ST_LEFT_OVER, 1'b1);
			else
				expect_value(val, idx, ST_OK, 1'b1);
		end else begin
			expect_value(val, idx, ST_OK, 1'b0);
		end
	endfunction

	// Model updates and output checks happen on the same edge the handshakes complete.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Timed out after %0d cycles.", cycle_count);
			$display("Regression FAIL");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready)
				load_register(slbd_cfg_idx_t'(cfg_index), cfg_data);
			in_fire = s_axis_tvalid && s_axis_tready;
			if (in_fire) begin
				void'(body_bytes.pop_front());
				decode_leb_byte(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (pending_values.size() == 0) begin
					errors++;
					$error("Unexpected item: value %0d index %0d status %0d last %0d",
						$signed(m_axis_tdata[31:0]), m_axis_tdata[63:32], m_axis_tuser,
						m_axis_tlast);
				end else begin
					want = pending_values.pop_front();
					if (m_axis_tdata[31:0] !== want.value) begin
						errors++;
						$error("decoded_value: expected %0d, actual %0d",
							$signed(want.value), $signed(m_axis_tdata[31:0]));
					end
					if (m_axis_tdata[63:32] !== want.index) begin
						errors++;
						$error("value_index: expected %0d, actual %0d", want.index,
							m_axis_tdata[63:32]);
					end
					if (m_axis_tuser !== 2'(want.status)) begin
						errors++;
						$error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
					end
					if (m_axis_tlast !== want.last) begin
						errors++;
						$error("last_value: expected %0d, actual %0d", want.last, m_axis_tlast);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	always @(negedge clk) begin
		if (!arst_n)
			s_axis_tvalid <= 1'b0;
		else if (s_axis_tvalid && !in_fire)
			s_axis_tvalid <= 1'b1;
		else if (body_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= body_bytes[0];
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= arst_n && hold_cycles == 0 && $urandom_range(99) >= recv_stall_pct;
	end

	task automatic wait_drained();
		while (body_bytes.size() > 0 || s_axis_tvalid || pending_values.size() > 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(slbd_cfg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_block(bit wide, logic [31:0] bb, logic [31:0] vc, int hold_len);
		wait_drained();
		write_reg(CFG_WIDE_VALUES, {31'd0, wide});
		write_reg(CFG_BLOCK_BYTES, bb);
		write_reg(CFG_VALUE_COUNT, vc);
		if (hold_len > 0)
			hold_cycles = hold_len;
		foreach (block_buf[i])
			body_bytes.push_back(block_buf[i]);
		block_buf.delete();
		blocks_run++;
	endtask

	function automatic int pick_value(bit wide);
		int v;
		if ($urandom_range(99) < 30) begin
			v = int'($urandom_range(255)) - 128;
		end else if ($urandom_range(99) < 40) begin
			case ($urandom_range(7))
				0: v = 0;
				1: v = -1;
				2: v = 63;
				3: v = -64;
				4: v = 64;
				5: v = -65;
				6: v = wide ? 32'sh7fff_ffff : 32767;
				default: v = wide ? 32'sh8000_0000 : -32768;
			endcase
		end else begin
			v = $urandom;
		end
		if (!wide)
			v = {{16{v[15]}}, v[15:0]};
		return v;
	endfunction

	// The optional padding appends one redundant sign group without exceeding the width.
	function automatic void append_leb(int v, bit wide, bit pad);
		int         x;
		int         n;
		bit         done;
		logic [7:0] b;
		x = v;
		n = 0;
		done = 1'b0;
		while (!done) begin
			b = {1'b0, x[6:0]};
			x = x >>> 7;
			n++;
			if ((x == 0 && !b[6]) || (x == -1 && b[6]))
				done = 1'b1;
			else
				b[7] = 1'b1;
			block_buf.push_back(b);
		end
		if (pad && n < (wide ? 5 : 3)) begin
			block_buf[$] = block_buf[$] | 8'h80;
			block_buf.push_back(v < 0 ? 8'h7f : 8'h00);
		end
	endfunction

	task automatic random_block(int nvals, int hold_len);
		logic [31:0] bb;
		logic [31:0] vc;
		int          mode;
		bit          wide;
		wide = $urandom_range(1);
		mode = hold_len > 0 ? 0 : $urandom_range(99);
		if (mode >= 90) begin
			repeat ($urandom_range(2, 12)) block_buf.push_back(8'($urandom));
			bb = $urandom_range(12);
			vc = $urandom_range(4);
		end else begin
			for (int k = 0; k < nvals; k++)
				append_leb(pick_value(wide), wide, $urandom_range(9) == 0);
			bb = block_buf.size();
			vc = nvals;
			if (mode >= 55 && mode < 65) begin
				repeat ($urandom_range(1, 3)) block_buf.push_back(8'($urandom));
				bb = block_buf.size();
			end else if (mode >= 65 && mode < 75) begin
				bb = $urandom_range(bb - 1);
			end else if (mode >= 75 && mode < 82) begin
				repeat ($urandom_range(5, 6)) block_buf.push_back(8'($urandom) | 8'h80);
				block_buf.push_back(8'($urandom));
				bb = block_buf.size();
				vc = nvals + 1;
			end else if (mode >= 82) begin
				bb = 32'hffff_ffff;
				vc = $urandom_range(1) ? 32'h0 : 32'hffff_ffff;
			end
		end
		if (hold_len == 0 && $urandom_range(3) == 0)
			repeat ($urandom_range(1, 2)) block_buf.push_back(8'($urandom));
		run_block(wide, bb, vc, hold_len);
	endtask

	initial begin
		int send_mix[4];
		int recv_mix[4];
		int base;
		send_mix = '{0, 84, 0, 8};
		recv_mix = '{0, 0, 84, 8};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Out of reset the declared size is zero, so the first byte overruns it and the
		// second one is dropped.
		body_bytes.push_back(8'h00);
		body_bytes.push_back(8'hff);

		block_buf = '{8'hff, 8'hff, 8'h01, 8'h80, 8'h80, 8'h7e, 8'hff, 8'hff, 8'h7f};
		run_block(1'b0, 32'd9, 32'd3, 0);
		block_buf = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h07, 8'h80, 8'h80, 8'h80, 8'h80, 8'h78,
			8'h3f};
		run_block(1'b1, 32'd11, 32'd2, 0);
		block_buf = '{8'h80, 8'h80, 8'h80};
		run_block(1'b0, 32'd3, 32'd1, 0);
		block_buf = '{8'h05};
		run_block(1'b1, 32'd0, 32'd1, 0);

		base = live_bytes;
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			send_idle_pct = send_mix[p];
			recv_stall_pct = recv_mix[p];
			if (p == 0)
				random_block(40, 300);
			while (live_bytes < base + BytesPerPhase * (p + 1))
				random_block($urandom_range(1, 6), 0);
		end
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Ran %0d blocks: %0d decoded bytes and %0d result items checked,",
			blocks_run, live_bytes, results_seen);
		$display("across four idle/stall mixes and one long output hold-off; %0d errors.",
			errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
